// ----- rtl/mspid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the motor speed PID block.
package mspid_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam int ACC_W = 48;
  localparam int INTEG_W = 48;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_SET_TARGET = 2'd0,
    ACT_FEEDBACK   = 2'd1,
    ACT_REZERO     = 2'd2,
    ACT_IGNORE     = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_CYCLE_TIME   = 3'd3,
    REG_TARGET_LIMIT = 3'd4,
    REG_DRIVE_LIMIT  = 3'd5,
    REG_ENC_COUNTS   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CYC   = 3'd1,
    OP_PTERM = 3'd2,
    OP_DTERM = 3'd3,
    OP_ILO   = 3'd4,
    OP_IHI   = 3'd5,
    OP_ISUM  = 3'd6,
    OP_IACC  = 3'd7
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CYC,
    ST_PTERM,
    ST_DTERM,
    ST_ILO,
    ST_IHI,
    ST_ISUM,
    ST_IACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic   accept;
    logic   capture;
    dp_op_t op;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    logic feedback;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [15:0]        target;
    logic signed [16:0]        prev_err;
    logic signed [INTEG_W-1:0] integ;
    logic [15:0]               last_angle;
    logic signed [39:0]        phase;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// ----- rtl/mspid_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
module mspid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mspid_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the motor speed PID block: steps the datapath through one item.
module mspid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mspid_pkg::stat_t   stat,
  output mspid_pkg::cmd_t    cmd
);
  import mspid_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    cmd.commit  = 1'b0;
    in_stall    = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.capture = 1'b1;
        state_next  = stat.feedback ? ST_CYC : ST_FINISH;
      end
      ST_CYC: begin
        cmd.op     = OP_CYC;
        state_next = ST_PTERM;
      end
      ST_PTERM: begin
        cmd.op     = OP_PTERM;
        state_next = ST_DTERM;
      end
      ST_DTERM: begin
        cmd.op     = OP_DTERM;
        state_next = ST_ILO;
      end
      ST_ILO: begin
        cmd.op     = OP_ILO;
        state_next = ST_IHI;
      end
      ST_IHI: begin
        cmd.op     = OP_IHI;
        state_next = ST_ISUM;
      end
      ST_ISUM: begin
        cmd.op     = OP_ISUM;
        state_next = ST_IACC;
      end
      ST_IACC: begin
        cmd.op     = OP_IACC;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/mspid_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the motor speed PID block: config, channel state, shared multiplier, result.
module mspid_dpath #(
  parameter int CHANNELS = mspid_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mspid_pkg::cmd_t    cmd,
  output mspid_pkg::stat_t   stat,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         action,
  input  logic [3:0]         channel,
  input  logic signed [15:0] target_speed,
  input  logic [15:0]        angle,
  input  logic signed [15:0] speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_channel,
  output logic signed [15:0] drive,
  output logic signed [39:0] phase,
  output logic               drive_valid
);
  import mspid_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [15:0] gain_p, gain_i, gain_d, cycle_time, encoder_counts;
  logic [14:0] target_limit, drive_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= 16'd256;
      gain_i         <= 16'd0;
      gain_d         <= 16'd0;
      cycle_time     <= 16'd66;
      target_limit   <= 15'd16384;
      drive_limit    <= 15'd16384;
      encoder_counts <= 16'd8192;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_P:       gain_p         <= cfg_data;
        REG_GAIN_I:       gain_i         <= cfg_data;
        REG_GAIN_D:       gain_d         <= cfg_data;
        REG_CYCLE_TIME:   cycle_time     <= cfg_data;
        REG_TARGET_LIMIT: target_limit   <= cfg_data[14:0];
        REG_DRIVE_LIMIT:  drive_limit    <= cfg_data[14:0];
        REG_ENC_COUNTS:   encoder_counts <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  logic [6:0]         ch_ext_in;
  logic [IDX_W-1:0]   idx_in;
  act_t               act_r;
  logic [3:0]         ch_r;
  logic [IDX_W-1:0]   idx_r;
  logic               present_r;
  logic signed [15:0] tspd_r;
  logic [15:0]        ang_r;
  logic signed [15:0] spd_r;

  assign ch_ext_in = {3'b000, channel};
  assign idx_in    = ch_ext_in[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r     <= act_t'(action);
      ch_r      <= channel;
      idx_r     <= idx_in;
      present_r <= (ch_ext_in < 7'(CHANNELS));
      tspd_r    <= target_speed;
      ang_r     <= angle;
      spd_r     <= speed;
    end
  end

  // channel record store; entries not yet written read as zero
  logic [REC_W-1:0]    ram_rdata;
  logic [REC_W-1:0]    ram_wdata;
  logic                ram_we;
  logic [CHANNELS-1:0] rec_ok;
  logic [CHANNELS-1:0] pending;
  rec_t                load_rec;

  mspid_ram #(
    .WIDTH (REC_W),
    .DEPTH (CHANNELS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (idx_in),
    .rdata (ram_rdata)
  );

  assign load_rec = rec_ok[idx_r] ? rec_t'(ram_rdata) : '0;

  // working registers
  logic signed [15:0]        target_r;
  logic signed [16:0]        prev_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic [15:0]               last_r;
  logic signed [39:0]        phase_r;
  logic signed [16:0]        err_r;
  logic signed [41:0]        prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [63:0]        ip_r;

  // combinational helpers
  logic signed [16:0]        err_load;
  logic signed [17:0]        err_sum, err_diff;
  logic signed [24:0]        mul_a;
  logic signed [16:0]        mul_b;
  logic signed [41:0]        mul_p;
  logic [16:0]               d17;
  logic signed [17:0]        d18, half18, n18, dadj;
  logic signed [39:0]        phase_step;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [63:0]        ip_bias, ip_next;
  logic signed [ACC_W-1:0]   acc_bias;
  logic signed [39:0]        quot, dlim, dclamp;
  logic signed [16:0]        t17, tlim;
  logic signed [15:0]        tnew;

  assign err_load = {load_rec.target[15], load_rec.target} - {spd_r[15], spd_r};
  assign err_sum  = {err_r[16], err_r} + {prev_r[16], prev_r};
  assign err_diff = {err_r[16], err_r} - {prev_r[16], prev_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_CYC: begin
        mul_a = {{7{err_sum[17]}}, err_sum};
        mul_b = {1'b0, cycle_time};
      end
      OP_PTERM: begin
        mul_a = {{8{err_r[16]}}, err_r};
        mul_b = {1'b0, gain_p};
      end
      OP_DTERM: begin
        mul_a = {{7{err_diff[17]}}, err_diff};
        mul_b = {1'b0, gain_d};
      end
      OP_ILO: begin
        mul_a = {1'b0, integ_r[23:0]};
        mul_b = {1'b0, gain_i};
      end
      OP_IHI: begin
        mul_a = {integ_r[47], integ_r[47:24]};
        mul_b = {1'b0, gain_i};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // encoder unwrap
  assign d17    = {1'b0, ang_r} - {1'b0, last_r};
  assign d18    = {d17[16], d17};
  assign half18 = {3'b000, encoder_counts[15:1]};
  assign n18    = {2'b00, encoder_counts};

  always_comb begin
    if (d18 < -half18) begin
      dadj = d18 + n18;
    end else if (d18 > half18) begin
      dadj = d18 - n18;
    end else begin
      dadj = d18;
    end
  end

  assign phase_step = phase_r + {{22{dadj[17]}}, dadj};

  // integral with saturation
  assign isum = {integ_r[INTEG_W-1], integ_r} + {{(INTEG_W-41){prod_r[41]}}, prod_r};
  assign integ_sat = (isum[INTEG_W] != isum[INTEG_W-1]) ?
                     (isum[INTEG_W] ? INTEG_MIN : INTEG_MAX) : isum[INTEG_W-1:0];

  // integral term: high partial shifted up, low partial, round-toward-zero bias
  assign ip_bias = (integ_r[INTEG_W-1] && (gain_i != 16'd0)) ? 64'sd131071 : 64'sd0;
  assign ip_next = {prod_r[39:0], 24'd0} + ip_r + ip_bias;

  // drive: truncate toward zero by 2^8, then clamp
  assign acc_bias = acc_r + (acc_r[ACC_W-1] ? 48'sd255 : 48'sd0);
  assign quot     = acc_bias[ACC_W-1:8];
  assign dlim     = {25'd0, drive_limit};

  always_comb begin
    if (quot > dlim) begin
      dclamp = dlim;
    end else if (quot < -dlim) begin
      dclamp = -dlim;
    end else begin
      dclamp = quot;
    end
  end

  // target clamp
  assign t17  = {tspd_r[15], tspd_r};
  assign tlim = {2'b00, target_limit};

  always_comb begin
    if (t17 > tlim) begin
      tnew = tlim[15:0];
    end else if (t17 < -tlim) begin
      tnew = 16'(-tlim);
    end else begin
      tnew = tspd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      target_r <= load_rec.target;
      prev_r   <= load_rec.prev_err;
      integ_r  <= load_rec.integ;
      last_r   <= load_rec.last_angle;
      phase_r  <= load_rec.phase;
      err_r    <= err_load;
    end
    case (cmd.op)
      OP_CYC: begin
        prod_r  <= mul_p;
        phase_r <= pending[idx_r] ? 40'sd0 : phase_step;
      end
      OP_PTERM: begin
        integ_r <= integ_sat;
        prod_r  <= mul_p;
      end
      OP_DTERM: begin
        acc_r  <= {{(ACC_W-42){prod_r[41]}}, prod_r};
        prod_r <= mul_p;
      end
      OP_ILO: begin
        acc_r  <= acc_r + {{(ACC_W-42){prod_r[41]}}, prod_r};
        prod_r <= mul_p;
      end
      OP_IHI: begin
        ip_r   <= {24'd0, prod_r[39:0]};
        prod_r <= mul_p;
      end
      OP_ISUM: begin
        ip_r <= ip_next;
      end
      OP_IACC: begin
        acc_r <= acc_r + {ip_r[63], ip_r[63:17]};
      end
      default: ;
    endcase
  end

  // commit
  assign ram_we = cmd.commit && present_r &&
                  ((act_r == ACT_SET_TARGET) || (act_r == ACT_FEEDBACK));
  assign ram_wdata = (act_r == ACT_SET_TARGET) ?
                     {tnew, prev_r, integ_r, last_r, phase_r} :
                     {target_r, err_r, integ_r, ang_r, phase_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_ok  <= '0;
      pending <= '1;
    end else if (cmd.commit && present_r) begin
      if (ram_we) begin
        rec_ok[idx_r] <= 1'b1;
      end
      if (act_r == ACT_REZERO) begin
        pending[idx_r] <= 1'b1;
      end else if (act_r == ACT_FEEDBACK) begin
        pending[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_channel <= ch_r;
      phase       <= present_r ? phase_r : 40'sd0;
      if (present_r && (act_r == ACT_FEEDBACK)) begin
        drive       <= dclamp[15:0];
        drive_valid <= 1'b1;
      end else begin
        drive       <= 16'sd0;
        drive_valid <= 1'b0;
      end
    end
  end

  assign stat.feedback = present_r && (act_r == ACT_FEEDBACK);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

// ----- rtl/motor_speed_pid_with_encoder_unwrap_unit.sv -----
`timescale 1ns / 1ps
// Top level of the multi-channel motor speed PID controller with encoder unwrap.
//
// Input beats (in_valid/in_stall) carry action, channel, target_speed, angle
// and speed. Every input beat yields one output beat (out_valid/out_stall)
// with out_channel, drive, phase and drive_valid, in input order.
// One item is in work at a time; in_stall is high while it is processed.
// A feedback beat goes from the load state through seven steps (ST_CYC to
// ST_IACC) on the single shared 25x17 multiplier and the integral adders
// to the finish state; set-target, re-zero and ignored beats go from the
// load state straight to the finish state.
// Channel state lives in one RAM (one record per channel, read-modify-write)
// with a per-channel valid flag, so reset takes effect at once with no
// clearing pass. Reset loads the default gains and limits, marks every
// channel for re-zero and empties the output register.
// When the receiver stalls, the finished result is held in the output
// register; the next beat is still accepted and processed, and only its
// write-back waits until the output register is free.
// Configuration writes (cfg_wr, cfg_index, cfg_data) take effect at once.
module motor_speed_pid_with_encoder_unwrap_unit #(
  parameter int CHANNELS = mspid_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [3:0]         channel,
  input  logic signed [15:0] target_speed,
  input  logic [15:0]        angle,
  input  logic signed [15:0] speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_channel,
  output logic signed [15:0] drive,
  output logic signed [39:0] phase,
  output logic               drive_valid
);
  import mspid_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mspid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mspid_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_wr       (cfg_wr),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .channel      (channel),
    .target_speed (target_speed),
    .angle        (angle),
    .speed        (speed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .drive        (drive),
    .phase        (phase),
    .drive_valid  (drive_valid)
  );

endmodule
